// ===== sv/ffha_pkg.sv =====
// Types and constants shared by the first-fit heap allocator files.
`default_nettype none
package ffha_pkg;

  localparam int unsigned HEADER_BYTES = 24;
  localparam logic [16:0] HDR          = 17'(HEADER_BYTES);
  localparam logic [16:0] HDR2         = 17'(2 * HEADER_BYTES);
  localparam logic [15:0] HEAP_RESET   = 16'hFFFF;
  localparam logic [6:0]  CNT_MAX      = 7'd127;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_COUNT = 2'd2;

  typedef struct packed {
    logic [15:0] offset;
    logic [15:0] size;
    logic        in_use;
    logic [7:0]  owner;
  } entry_t;

  typedef struct packed {
    logic [15:0] a;
    logic [16:0] b;
    logic        sub;
    logic [16:0] k;
  } unit_in_t;

  typedef struct packed {
    logic [17:0] r;
    logic        neg;
    logic        lt;
    logic        eq;
  } unit_out_t;

endpackage
`default_nettype wire

// ===== sv/ffha_ifs.sv =====
// Handshake channel interfaces: request, response and configuration.
`default_nettype none
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] size_bytes;
  logic [15:0] user_offset;
  logic [7:0]  task_id;
  modport source (output valid, operation, size_bytes, user_offset, task_id, input ready);
  modport sink   (input valid, operation, size_bytes, user_offset, task_id, output ready);
endinterface

interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [15:0] result_offset;
  logic [6:0]  fragment_count;
  modport source (output valid, status, result_offset, fragment_count, input ready);
  modport sink   (input valid, status, result_offset, fragment_count, output ready);
endinterface

interface ffha_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] heap_bytes;
  modport source (output valid, heap_bytes, input ready);
  modport sink   (input valid, heap_bytes, output ready);
endinterface
`default_nettype wire

// ===== sv/first_fit_heap_allocator.sv =====
// Top level: first-fit heap allocator sequencer around the block table.
//
//  channel | dir | payload
//  req     | in  | operation, size_bytes, user_offset, task_id
//  rsp     | out | status, result_offset, fragment_count
//  cfg     | in  | heap_bytes
//
// An item scans the table one entry a cycle (one read port); an alloc that
// splits then shifts each entry above up by one, and a free that merges
// shifts the entries above down.
// Reset or a heap_bytes write rebuilds the table through S_INIT0 and S_INIT1.
// A finished result waits in the output register; the next beat may be taken.
`default_nettype none
module first_fit_heap_allocator #(
  parameter int MAX_BLOCKS = 64
) (
  input wire logic clk,
  input wire logic rst,
  ffha_req_if.sink   req,
  ffha_rsp_if.source rsp,
  ffha_cfg_if.sink   cfg
);
  import ffha_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  localparam logic [4:0] S_INIT0  = 5'd0;
  localparam logic [4:0] S_INIT1  = 5'd1;
  localparam logic [4:0] S_IDLE   = 5'd2;
  localparam logic [4:0] S_SCAN   = 5'd3;
  localparam logic [4:0] S_A_REM  = 5'd4;
  localparam logic [4:0] S_A_UOFF = 5'd5;
  localparam logic [4:0] S_A_NOFF = 5'd6;
  localparam logic [4:0] S_A_NSZ  = 5'd7;
  localparam logic [4:0] S_UP     = 5'd8;
  localparam logic [4:0] S_A_WNEW = 5'd9;
  localparam logic [4:0] S_A_WF   = 5'd10;
  localparam logic [4:0] S_F_RDN  = 5'd11;
  localparam logic [4:0] S_F_WTN  = 5'd12;
  localparam logic [4:0] S_F_M1   = 5'd13;
  localparam logic [4:0] S_F_M2   = 5'd14;
  localparam logic [4:0] S_F_M3   = 5'd15;
  localparam logic [4:0] S_F_M4   = 5'd16;
  localparam logic [4:0] S_F_WR   = 5'd17;
  localparam logic [4:0] S_DOWN   = 5'd18;
  localparam logic [4:0] S_DONE   = 5'd19;

  logic [4:0]    state;
  logic [15:0]   heap;
  logic [CW-1:0] total, idx, cur, k, rd_idx, pend_addr;
  logic          rd_vld, pend;
  logic [1:0]    op;
  logic [16:0]   need;
  logic [15:0]   uoff_in, thr;
  logic [7:0]    task_r;
  entry_t        ent, prev, rdata, wdata;
  logic [15:0]   rem, roff, noff, nsz, acc, nsize;
  logic          nfree, pfree, split, status;
  logic [1:0]    dsh;
  logic [6:0]    cnt;
  logic          out_valid, out_status;
  logic [15:0]   out_offset;
  logic [6:0]    out_count;
  logic          we;
  logic [CW-1:0] waddr, raddr, cur_m1;
  unit_in_t      u_in;
  unit_out_t     u;
  logic          split_now;

  ffha_table #(.DEPTH(MAX_BLOCKS)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr[IW-1:0]),
    .wdata(wdata),
    .raddr(raddr[IW-1:0]),
    .rdata(rdata)
  );

  ffha_unit u_unit (.u_in(u_in), .u_out(u));

  assign req.ready          = (state == S_IDLE);
  assign cfg.ready          = 1'b1;
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.result_offset  = out_offset;
  assign rsp.fragment_count = out_count;

  assign cur_m1    = cur - 1'b1;
  assign split_now = !u.neg && (u.r != 18'd0) && (total < CW'(MAX_BLOCKS));

  always_comb begin
    u_in = '0;
    case (state)
      S_INIT1: begin
        u_in.a = heap; u_in.b = HDR2; u_in.sub = 1'b1;
      end
      S_SCAN: begin
        case (op)
          OP_ALLOC: begin u_in.a = rdata.size; u_in.b = need; u_in.sub = 1'b1; end
          OP_FREE:  begin u_in.a = rdata.offset; u_in.b = HDR; u_in.k = {1'b0, uoff_in}; end
          default:  begin u_in.a = rdata.size; u_in.b = HDR; u_in.k = {1'b0, thr}; end
        endcase
      end
      S_A_REM:  begin u_in.a = ent.size; u_in.b = need; u_in.sub = 1'b1; end
      S_A_UOFF: begin u_in.a = ent.offset; u_in.b = HDR; end
      S_A_NOFF: begin u_in.a = roff; u_in.b = need; end
      S_A_NSZ:  begin u_in.a = rem; u_in.b = HDR; u_in.sub = 1'b1; end
      S_F_M1:   begin u_in.a = acc; u_in.b = HDR; end
      S_F_M2:   begin u_in.a = acc; u_in.b = {1'b0, nsize}; end
      S_F_M3:   begin u_in.a = acc; u_in.b = HDR; end
      S_F_M4:   begin u_in.a = acc; u_in.b = {1'b0, prev.size}; end
      default:  u_in = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    case (state)
      S_INIT0: begin
        we = 1'b1;
        wdata.in_use = 1'b1;
      end
      S_INIT1: begin
        we = 1'b1;
        waddr = CW'(1);
        wdata.offset = HDR[15:0];
        wdata.size   = u.neg ? 16'd0 : u.r[15:0];
      end
      S_SCAN: raddr = idx;
      S_UP: begin
        raddr = cur_m1;
        we = pend; waddr = pend_addr; wdata = rdata;
      end
      S_DOWN: begin
        raddr = cur;
        we = pend; waddr = pend_addr; wdata = rdata;
      end
      S_F_RDN: raddr = k + 1'b1;
      S_A_WNEW: begin
        we = 1'b1;
        waddr = k + 1'b1;
        wdata.offset = noff;
        wdata.size   = nsz;
      end
      S_A_WF: begin
        we = 1'b1;
        waddr = k;
        wdata.offset = ent.offset;
        wdata.size   = split ? need[15:0] : ent.size;
        wdata.in_use = 1'b1;
        wdata.owner  = task_r;
      end
      S_F_WR: begin
        we = 1'b1;
        waddr = pfree ? cur_m1 : k;
        wdata.offset = pfree ? prev.offset : ent.offset;
        wdata.size   = acc;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT0;
      heap      <= HEAP_RESET;
      total     <= CW'(2);
      out_valid <= 1'b0;
      rd_vld    <= 1'b0;
      pend      <= 1'b0;
    end else begin
      rd_vld <= 1'b0;
      pend   <= 1'b0;
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT0: begin
          total <= CW'(2);
          state <= S_INIT1;
        end
        S_INIT1: state <= S_IDLE;
        S_IDLE: begin
          if (req.valid) begin
            op      <= req.operation;
            need    <= ({1'b0, req.size_bytes} + 17'd3) & ~17'd3;
            uoff_in <= req.user_offset;
            thr     <= req.size_bytes;
            task_r  <= req.task_id;
            idx     <= '0;
            cnt     <= '0;
            roff    <= '0;
            status  <= 1'b0;
            if ((req.operation != OP_ALLOC && req.operation != OP_FREE &&
                 req.operation != OP_COUNT) ||
                (req.operation == OP_ALLOC && req.size_bytes == 16'd0)) begin
              status <= 1'b1;
              state  <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (idx < total) begin
            idx    <= idx + 1'b1;
            rd_vld <= 1'b1;
            rd_idx <= idx;
          end
          if (rd_vld) begin
            ent  <= rdata;
            prev <= ent;
            k    <= rd_idx;
            case (op)
              OP_ALLOC: begin
                if (!rdata.in_use && !u.neg) begin
                  state <= S_A_REM;
                end
              end
              OP_FREE: begin
                if (rd_idx != '0 && u.eq) begin
                  if (rdata.in_use && rdata.owner == task_r) begin
                    acc   <= rdata.size;
                    pfree <= !ent.in_use;
                    state <= S_F_RDN;
                  end else begin
                    status <= 1'b1;
                    state  <= S_DONE;
                  end
                end
              end
              default: begin
                if (!rdata.in_use && u.lt && cnt != CNT_MAX) begin
                  cnt <= cnt + 1'b1;
                end
              end
            endcase
          end else if (idx >= total) begin
            status <= (op != OP_COUNT);
            state  <= S_DONE;
          end
        end
        S_A_REM: begin
          rem   <= u.r[15:0];
          state <= S_A_UOFF;
        end
        S_A_UOFF: begin
          roff  <= u.r[15:0];
          state <= S_A_NOFF;
        end
        S_A_NOFF: begin
          noff  <= u.r[15:0];
          state <= S_A_NSZ;
        end
        S_A_NSZ: begin
          nsz   <= u.r[15:0];
          split <= split_now;
          cur   <= total;
          state <= split_now ? S_UP : S_A_WF;
        end
        S_UP: begin
          if (cur > k + 1'b1) begin
            pend      <= 1'b1;
            pend_addr <= cur;
            cur       <= cur_m1;
          end else if (!pend) begin
            state <= S_A_WNEW;
          end
        end
        S_A_WNEW: begin
          total <= total + 1'b1;
          state <= S_A_WF;
        end
        S_A_WF: state <= S_DONE;
        S_F_RDN: begin
          if (k + 1'b1 < total) begin
            state <= S_F_WTN;
          end else begin
            nfree <= 1'b0;
            state <= S_F_M3;
          end
        end
        S_F_WTN: begin
          nfree <= !rdata.in_use;
          nsize <= rdata.size;
          state <= rdata.in_use ? S_F_M3 : S_F_M1;
        end
        S_F_M1: begin
          acc   <= u.r[15:0];
          state <= S_F_M2;
        end
        S_F_M2: begin
          acc   <= u.r[15:0];
          state <= S_F_M3;
        end
        S_F_M3: begin
          cur <= k;
          if (pfree) begin
            acc   <= u.r[15:0];
            state <= S_F_M4;
          end else begin
            state <= S_F_WR;
          end
        end
        S_F_M4: begin
          acc   <= u.r[15:0];
          state <= S_F_WR;
        end
        S_F_WR: begin
          dsh <= {1'b0, nfree} + {1'b0, pfree};
          cur <= pfree ? (k + 1'b1 + CW'(nfree)) : (k + CW'(2));
          state <= (nfree || pfree) ? S_DOWN : S_DONE;
        end
        S_DOWN: begin
          if (cur < total) begin
            pend      <= 1'b1;
            pend_addr <= cur - CW'(dsh);
            cur       <= cur + 1'b1;
          end else if (!pend) begin
            total <= total - CW'(dsh);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= status;
            out_offset <= status ? 16'd0 : roff;
            out_count  <= cnt;
            state      <= S_IDLE;
          end
        end
        default: state <= S_INIT0;
      endcase
      if (cfg.valid) begin
        heap  <= cfg.heap_bytes;
        state <= S_INIT0;
      end
    end
  end

  a_total_range: assert property (@(posedge clk) disable iff (rst)
    total >= CW'(2) && total <= CW'(MAX_BLOCKS))
    else $error("block count out of range");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && !cfg.valid |=> state == S_SCAN || state == S_DONE)
    else $error("accepted beat did not start work");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !we)
    else $error("table written while idle");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status |-> out_offset == 16'd0 && out_count == 7'd0)
    else $error("error result carries data");

endmodule
`default_nettype wire

// ===== sv/ffha_table.sv =====
// Block table memory: one write port, one registered read port.
`default_nettype none
module ffha_table #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire ffha_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output ffha_pkg::entry_t     rdata
);
  import ffha_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/ffha_unit.sv =====
// Shared add/subtract and compare unit.
`default_nettype none
module ffha_unit (
  input  wire ffha_pkg::unit_in_t u_in,
  output ffha_pkg::unit_out_t     u_out
);
  import ffha_pkg::*;

  logic [17:0] bx;
  logic [17:0] r;

  always_comb begin
    bx = u_in.sub ? (18'd0 - {1'b0, u_in.b}) : {1'b0, u_in.b};
    r  = {2'b00, u_in.a} + bx;
    u_out.r   = r;
    u_out.neg = r[17];
    u_out.lt  = r < {1'b0, u_in.k};
    u_out.eq  = r == {1'b0, u_in.k};
  end

endmodule
`default_nettype wire
